// ===== sv/fppa_pkg.sv =====
// Package for the fit-policy partition allocator: word types, policy codes,
// controller handshake structs and width helpers. No dependencies.
`timescale 1ns / 1ps

package fppa_pkg;

   localparam int BLOCKS       = 16;
   localparam int SIZE_WIDTH   = 16;
   localparam int IDX_W        = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int BLK_FIELD_W  = 4;
   localparam int SIZE_FIELD_W = 16;
   localparam int POL_W        = 2;

   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [BLK_FIELD_W-1:0]  block_index;
      logic [SIZE_FIELD_W-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic                    granted;
      logic [BLK_FIELD_W-1:0]  chosen_block;
      logic [SIZE_FIELD_W-1:0] remaining_size;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;      // capture the accepted word, clear scan state
      logic scan_step;  // examine one table entry
      logic load_do;    // finish a load word
      logic alloc_do;   // finish a request word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_is_load;
      logic scan_last;
      logic first_hit;
   } sts_type;

   function automatic logic [SIZE_WIDTH-1:0] size_from_field(
      input logic [SIZE_FIELD_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[SIZE_WIDTH-1:0];
   endfunction

   function automatic logic [SIZE_FIELD_W-1:0] size_to_field(
      input logic [SIZE_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[SIZE_FIELD_W-1:0];
   endfunction

   function automatic logic [BLK_FIELD_W-1:0] blk_to_field(input logic [IDX_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[BLK_FIELD_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] blk_from_field(input logic [BLK_FIELD_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[IDX_W-1:0];
   endfunction

endpackage

// ===== sv/fppa_ctrl.sv =====
// Sequencer for the allocator: accept, load or scan, update.
// Depends on fppa_pkg.
`timescale 1ns / 1ps

module fppa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fppa_pkg::sts_type sts,
   output fppa_pkg::cmd_type cmd
);
   import fppa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = sts.req_is_load ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            cmd.load_do = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last || sts.first_hit) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.alloc_do = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/fppa_dpath.sv =====
// Datapath for the allocator: free-size table, policy register, scan
// counter, running pick and result register. Depends on fppa_pkg.
`timescale 1ns / 1ps

module fppa_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  fppa_pkg::req_type            req_data,
   input  logic                         csr_we,
   input  logic [fppa_pkg::POL_W-1:0]   csr_data,
   input  fppa_pkg::cmd_type            cmd,
   output fppa_pkg::sts_type            sts,
   output logic                         rsp_valid,
   output fppa_pkg::rsp_type            rsp_data
);
   import fppa_pkg::*;

   logic [SIZE_WIDTH-1:0]  table_ff [BLOCKS];
   logic [POL_W-1:0]       policy_ff;
   logic                   mode_ff;
   logic [BLK_FIELD_W-1:0] idx_ff;
   logic [SIZE_WIDTH-1:0]  size_ff;
   logic [IDX_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       pick_ff;
   logic [SIZE_WIDTH-1:0]  pick_size_ff;
   logic                   found_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [SIZE_WIDTH-1:0]  entry;
   logic                   fits;
   logic                   take;
   logic                   load_ok;
   logic [IDX_W-1:0]       load_idx;
   logic [SIZE_WIDTH-1:0]  left;

   assign entry    = table_ff[cnt_ff];
   assign fits     = (entry >= size_ff);
   assign take     = fits && (!found_ff
                     || ((policy_ff == POL_BEST)  && (entry < pick_size_ff))
                     || ((policy_ff == POL_WORST) && (entry > pick_size_ff)));
   assign load_ok  = (32'(idx_ff) < BLOCKS);
   assign load_idx = blk_from_field(idx_ff);
   assign left     = pick_size_ff - size_ff;

   assign sts.req_is_load = (req_data.mode == MODE_LOAD);
   assign sts.scan_last   = (cnt_ff == IDX_W'(BLOCKS - 1));
   assign sts.first_hit   = fits && (policy_ff != POL_BEST) && (policy_ff != POL_WORST);

   // table and policy
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BLOCKS; k++) begin
            table_ff[k] <= '0;
         end
         policy_ff <= POL_FIRST;
      end else begin
         if (csr_we) begin
            policy_ff <= csr_data;
         end
         if (cmd.load_do && load_ok) begin
            table_ff[load_idx] <= size_ff;
         end
         if (cmd.alloc_do && found_ff) begin
            table_ff[pick_ff] <= left;
         end
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.latch) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_data.mode;
         idx_ff  <= req_data.block_index;
         size_ff <= size_from_field(req_data.size_value);
      end
      if (cmd.scan_step && take) begin
         pick_ff      <= cnt_ff;
         pick_size_ff <= entry;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.load_do || cmd.alloc_do;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_do) begin
         rsp_ff.granted        <= load_ok;
         rsp_ff.chosen_block   <= load_ok ? idx_ff : '0;
         rsp_ff.remaining_size <= load_ok ? size_to_field(size_ff) : '0;
      end else if (cmd.alloc_do) begin
         rsp_ff.granted        <= found_ff;
         rsp_ff.chosen_block   <= found_ff ? blk_to_field(pick_ff) : '0;
         rsp_ff.remaining_size <= found_ff ? size_to_field(left) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && found_ff) |-> (pick_size_ff >= size_ff))
      else $error("held pick smaller than request");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.load_do || cmd.alloc_do))
      else $error("result word without a finishing step");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.granted) |->
         ((rsp_ff.chosen_block == '0) && (rsp_ff.remaining_size == '0)))
      else $error("refused word carries data");

   a_load_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.load_do |-> (mode_ff == MODE_LOAD))
      else $error("load finish on a request word");

endmodule

// ===== sv/fit_policy_partition_allocator_unit.sv =====
// Top level of the fit-policy partition allocator: sequencer plus datapath.
// Depends on fppa_pkg, fppa_ctrl and fppa_dpath.
`timescale 1ns / 1ps

//  channel   | ports                          | handshake
//  ----------+--------------------------------+-------------------------------
//  request   | start, busy, req_data          | taken when start && !busy
//  result    | rsp_valid, rsp_data            | one-cycle strobe, no back-pressure
//  register  | csr_valid, csr_ready, csr_data | written when valid && ready
//
//  Load word: the accepted word is latched, then the load state writes the table
//  and the result strobe is registered from it. Request word: 16 entries are
//  read one per cycle through the single table read port, or fewer under first
//  fit, which stops at the first entry that holds the request.
//  The next word is accepted in the cycle the result strobe is shown.
//  Synchronous reset clears the table to zero and the policy to first fit.
//  The receiver cannot stall; csr_ready is low while busy.

module fit_policy_partition_allocator_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fppa_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output fppa_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fppa_pkg::POL_W-1:0] csr_data
);
   import fppa_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    csr_we;

   // policy changes only between words
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   fppa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   fppa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result word always comes straight after the block was busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without work");

endmodule

// ===== verif/fppa_checker.sv =====
// Checker for the fit-policy partition allocator: mirrors the free-size table
// and policy, predicts each result word and compares it. Depends on fppa_pkg.
`timescale 1ns / 1ps

module fppa_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  fppa_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  fppa_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [fppa_pkg::POL_W-1:0] csr_data,
   output int                         outstanding,
   output int                         mismatches
);
   import fppa_pkg::*;

   localparam int NO_PICK = -1;

   logic [SIZE_WIDTH-1:0] free_tab [BLOCKS];
   logic [POL_W-1:0]      policy;
   rsp_type               due_words [$];
   int                    err_cnt = 0;

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   // Applies one word to the mirrored table and returns the result it gives.
   function automatic rsp_type place_or_load(input req_type w);
      rsp_type               r;
      logic [SIZE_WIDTH-1:0] want;
      int                    pick;
      r    = '0;
      want = SIZE_WIDTH'(w.size_value);
      if (w.mode == MODE_LOAD) begin
         if (int'(w.block_index) < BLOCKS) begin
            free_tab[w.block_index] = want;
            r.granted        = 1'b1;
            r.chosen_block   = w.block_index;
            r.remaining_size = SIZE_FIELD_W'(want);
         end
         return r;
      end
      pick = NO_PICK;
      for (int k = 0; k < BLOCKS; k++) begin
         if (free_tab[k] >= want) begin
            if (pick == NO_PICK) begin
               pick = k;
               if (policy != POL_BEST && policy != POL_WORST) break;
            end else if (policy == POL_BEST && free_tab[k] < free_tab[pick]) begin
               pick = k;
            end else if (policy == POL_WORST && free_tab[k] > free_tab[pick]) begin
               pick = k;
            end
         end
      end
      if (pick == NO_PICK) return r;
      free_tab[pick]   = free_tab[pick] - want;
      r.granted        = 1'b1;
      r.chosen_block   = BLK_FIELD_W'(pick);
      r.remaining_size = SIZE_FIELD_W'(free_tab[pick]);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < BLOCKS; k++) free_tab[k] = '0;
         policy = POL_FIRST;
         due_words.delete();
      end else begin
         if (rsp_valid) begin
            if (due_words.size() == 0) begin
               $error("result word with nothing expected: %p", rsp_data);
               err_cnt++;
            end else begin
               want = due_words.pop_front();
               if (rsp_data.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_data.granted);
                  err_cnt++;
               end
               if (rsp_data.chosen_block !== want.chosen_block) begin
                  $error("chosen_block: expected %0d, got %0d",
                         want.chosen_block, rsp_data.chosen_block);
                  err_cnt++;
               end
               if (rsp_data.remaining_size !== want.remaining_size) begin
                  $error("remaining_size: expected %0d, got %0d",
                         want.remaining_size, rsp_data.remaining_size);
                  err_cnt++;
               end
            end
         end
         if (csr_valid && csr_ready) policy = csr_data;
         if (start && !busy) due_words.push_back(place_or_load(req_data));
      end
      outstanding <= due_words.size();
      mismatches  <= err_cnt;
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for fit_policy_partition_allocator_unit: clock, reset,
// directed and random stimulus, verdict. Depends on fppa_pkg and fppa_checker.
`timescale 1ns / 1ps

module tb_top;
   import fppa_pkg::*;

   // Policy code 3 is not defined by the block and must fall back to first fit
   localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 235;
   localparam int MAX_GAP     = 20;
   localparam int TAIL_CYCLES = 40;        // well past the longest request word
   localparam int CYCLE_LIMIT = 500000;    // well above the worst-case run length

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [POL_W-1:0] csr_data;
   int               outstanding;
   int               mismatches;
   int               cycle_count = 0;

   fit_policy_partition_allocator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Checker sits beside the block and only watches its ports
   fppa_checker chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_type make_word(input logic m, input int blk, input int sz);
      req_type w;
      w.mode        = m;
      w.block_index = BLK_FIELD_W'(blk);
      w.size_value  = SIZE_FIELD_W'(sz);
      return w;
   endfunction

   // Boundary sizes, picked often so that equal sizes (tie-breaks) and
   // exact fits turn up regularly
   function automatic logic [SIZE_FIELD_W-1:0] corner_size();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h00ff;
         3:       return 16'h0100;
         4:       return 16'h7fff;
         5:       return 16'h8000;
         6:       return 16'hfffe;
         default: return 16'hffff;
      endcase
   endfunction

   // Loads lean towards large sizes, requests towards small ones, so the
   // table neither stays empty nor never fills; about half the words are
   // requests so grants, refusals and drained blocks all occur.
   function automatic req_type random_word();
      req_type w;
      w.block_index = BLK_FIELD_W'($urandom_range(15));
      if ($urandom_range(99) < 55) begin
         w.mode = MODE_ALLOC;
         case ($urandom_range(3))
            0:       w.size_value = corner_size();
            1:       w.size_value = SIZE_FIELD_W'($urandom_range(255));
            2:       w.size_value = SIZE_FIELD_W'($urandom_range(4095));
            default: w.size_value = SIZE_FIELD_W'($urandom);
         endcase
      end else begin
         w.mode = MODE_LOAD;
         case ($urandom_range(2))
            0:       w.size_value = corner_size();
            1:       w.size_value = SIZE_FIELD_W'($urandom);
            default: w.size_value = SIZE_FIELD_W'($urandom_range(4095));
         endcase
      end
      return w;
   endfunction

   // Hands one word over. start is only dropped when a gap is wanted, so
   // back-to-back words keep it high without a same-step drop and raise.
   task automatic send_word(input req_type w, input int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every result word is back, leaving the block idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Register writes only happen with the block drained
   task automatic set_policy(input logic [POL_W-1:0] p);
      drain();
      csr_data  <= p;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [POL_W-1:0] phase_pol [PHASES];
      int               phase_idle [PHASES];

      phase_pol  = '{POL_BEST, POL_WORST, POL_FIRST, POL_SPARE,
                     POL_WORST, POL_BEST, POL_SPARE, POL_FIRST};
      // sender idle share per phase; the no-idle phases keep the block saturated
      phase_idle = '{0, 58, 0, 30, 58, 0, 30, 58};

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: table fresh from reset, first fit by default ---
      send_word(make_word(MODE_ALLOC, 15, 0), 0);       // zero-size fits an empty block
      send_word(make_word(MODE_ALLOC, 0, 1), 0);        // nothing free: refused
      send_word(make_word(MODE_LOAD, 0, 100), 0);
      send_word(make_word(MODE_LOAD, 3, 50), 0);
      send_word(make_word(MODE_LOAD, 9, 50), 0);        // ties with block 3
      send_word(make_word(MODE_LOAD, 7, 200), 0);
      send_word(make_word(MODE_LOAD, 15, 16'hffff), 0);
      send_word(make_word(MODE_LOAD, 12, 0), 0);
      send_word(make_word(MODE_ALLOC, 4, 50), 0);       // lowest block that holds it
      send_word(make_word(MODE_ALLOC, 0, 16'hffff), 0); // exact fit, drains block 15
      send_word(make_word(MODE_ALLOC, 10, 16'hffff), 0);// refused, table untouched

      set_policy(POL_BEST);
      send_word(make_word(MODE_ALLOC, 0, 40), 0);       // tie on smallest: lower index
      send_word(make_word(MODE_ALLOC, 5, 0), 0);        // zero size under best fit
      send_word(make_word(MODE_ALLOC, 0, 201), 0);      // refused

      set_policy(POL_WORST);
      send_word(make_word(MODE_ALLOC, 0, 10), 0);
      send_word(make_word(MODE_ALLOC, 0, 0), 0);        // zero size under worst fit
      send_word(make_word(MODE_ALLOC, 0, 300), 0);      // refused

      set_policy(POL_SPARE);
      send_word(make_word(MODE_ALLOC, 0, 50), 0);
      send_word(make_word(MODE_LOAD, 5, 16'haaaa), 0);
      send_word(make_word(MODE_LOAD, 10, 16'h5555), 0);
      send_word(make_word(MODE_ALLOC, 15, 16'h5555), 0);
      send_word(make_word(MODE_ALLOC, 10, 16'haaaa), 0);

      // --- random phases, each under its own policy and idle pattern ---
      for (int ph = 0; ph < PHASES; ph++) begin
         set_policy(phase_pol[ph]);
         for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), phase_idle[ph]);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
